// ===== hw/rtl/cshake_prefix_bytepad_packer_unit_macros.svh =====
// assertion macros used by the checker of the cshake prefix packer
`ifndef CSHAKE_PREFIX_BYTEPAD_PACKER_UNIT_MACROS_SVH
`define CSHAKE_PREFIX_BYTEPAD_PACKER_UNIT_MACROS_SVH

// clocked check, switched off while reset is held
`define CPBP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) else $error(msg);

// clocked check that also holds through reset
`define CPBP_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);

`endif

// ===== hw/rtl/cpbp_pkg.sv =====
// shared types and constants of the cshake prefix packer
`timescale 1ns / 1ps

package cpbp_pkg;

  // field widths
  localparam int LANE_W    = 64;
  localparam int LEN64_W   = 64;
  localparam int RATE_W    = 5;
  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int DBITS_W   = 4;

  // encoded chunk sizes: one left_encode is at most nine bytes,
  // the begin chunk adds the two bytes of the rate encoding
  localparam int ENC_W     = 72;
  localparam int CHUNK_W   = 88;
  localparam int CLEN_W    = 7;

  localparam logic [RATE_W-1:0] RATE_RESET = 5'd21;
  localparam logic [BYTE_W-1:0] BYTE_MASK  = 8'hFF;

  localparam int MAX_RATE_LANES_DEF = 25;
  localparam int QUEUE_DEPTH_DEF    = 2;

  // input operation codes
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN  = 2'd0,
    OP_SWITCH = 2'd1,
    OP_DATA   = 2'd2,
    OP_FINISH = 2'd3
  } op_t;

  // commands handed from the front to the back
  typedef enum logic [1:0] {
    CMD_BEGIN  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t            kind;
    logic [CHUNK_W-1:0]   chunk;
    logic [CLEN_W-1:0]    len;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_port_t;

endpackage

// ===== hw/rtl/cpbp_ifs.sv =====
// valid/ready channel interfaces of the cshake prefix packer
`timescale 1ns / 1ps

interface cpbp_in_if
  import cpbp_pkg::*;
  ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [LEN64_W-1:0]   name_bit_length;
  logic [LEN64_W-1:0]   custom_bit_length;
  logic [BYTE_W-1:0]    data_byte;
  logic [DBITS_W-1:0]   data_bits;

  modport source (
    output valid, operation, name_bit_length, custom_bit_length, data_byte, data_bits,
    input  ready
  );
  modport sink (
    input  valid, operation, name_bit_length, custom_bit_length, data_byte, data_bits,
    output ready
  );
endinterface

interface cpbp_out_if
  import cpbp_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [LANE_W-1:0]  lane;
  logic               block_end;
  logic               last;

  modport source (
    output valid, lane, block_end, last,
    input  ready
  );
  modport sink (
    input  valid, lane, block_end, last,
    output ready
  );
endinterface

// ===== hw/rtl/cshake_prefix_bytepad_packer_unit.sv =====
// top level of the cshake prefix packer: rate register, front, queue and back
// throughput: one item per cycle while the queue has room; the back emits one lane per cycle through its single
// result register while that register can take it, and holds further commands back while padding runs
// reset: synchronous, active low; clears phase, queue, packing and result valid, rate to 21
`timescale 1ns / 1ps

module cshake_prefix_bytepad_packer_unit
  import cpbp_pkg::*;
  #(
  parameter int MAX_RATE_LANES = MAX_RATE_LANES_DEF,
  parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  cpbp_in_if.sink           in_ch,
  cpbp_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [RATE_W-1:0] cfg_wdata
);

  logic [RATE_W-1:0] rate_lanes_r, rate_lanes_nxt;
  logic [RATE_W-1:0] eff_rate;
  q_port_t           push;
  q_port_t           head;
  logic              q_full;
  logic              pop;

  // rate register
  assign rate_lanes_nxt = cfg_we ? cfg_wdata : rate_lanes_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_lanes_r <= RATE_RESET;
    end else begin
      rate_lanes_r <= rate_lanes_nxt;
    end
  end

  // clamp the rate into the supported range
  always_comb begin
    if (rate_lanes_r == '0) begin
      eff_rate = RATE_W'(1);
    end else if (rate_lanes_r > RATE_W'(MAX_RATE_LANES)) begin
      eff_rate = RATE_W'(MAX_RATE_LANES);
    end else begin
      eff_rate = rate_lanes_r;
    end
  end

  cpbp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_rate (eff_rate),
    .in_ch    (in_ch),
    .q_full   (q_full),
    .push     (push)
  );

  cpbp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .full  (q_full),
    .head  (head),
    .pop   (pop)
  );

  cpbp_back #(
    .MAX_RATE_LANES (MAX_RATE_LANES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .eff_rate (eff_rate),
    .head     (head),
    .pop      (pop),
    .out_ch   (out_ch)
  );

endmodule

// ===== hw/rtl/cpbp_front.sv =====
// front end: accepts items, tracks the string phase and encodes the bits to append
`timescale 1ns / 1ps

module cpbp_front
  import cpbp_pkg::*;
  (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RATE_W-1:0] eff_rate,
  cpbp_in_if.sink           in_ch,
  input  logic              q_full,
  output q_port_t           push
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_NAME   = 3'b010,
    PH_CUSTOM = 3'b100
  } phase_t;

  typedef struct packed {
    logic [3:0]       nbytes;
    logic [ENC_W-1:0] bits;
  } lenc_t;

  // left_encode: byte count, then the value big-endian, in stream order
  function automatic lenc_t left_encode(input logic [LEN64_W-1:0] v);
    lenc_t r;
    r.nbytes = 4'd1;
    r.bits   = '0;
    for (int i = 1; i < LEN64_W / BYTE_W; i++) begin
      if (v[BYTE_W*i +: BYTE_W] != '0) r.nbytes = 4'(i + 1);
    end
    r.bits[BYTE_W-1:0] = {4'd0, r.nbytes};
    for (int j = 0; j < LEN64_W / BYTE_W; j++) begin
      for (int k = 0; k < LEN64_W / BYTE_W; k++) begin
        if (4'(j + k + 1) == r.nbytes) begin
          r.bits[BYTE_W + BYTE_W*j +: BYTE_W] = v[BYTE_W*k +: BYTE_W];
        end
      end
    end
    return r;
  endfunction

  // bit length of an encoding with n value bytes
  function automatic logic [CLEN_W-1:0] enc_len(input logic [3:0] n);
    return CLEN_W'({n, 3'b000}) + CLEN_W'(BYTE_W);
  endfunction

  phase_t               phase_r, phase_nxt;
  logic                 empty_r, empty_nxt;
  logic [LEN64_W-1:0]   cust_len_r, cust_len_nxt;
  logic                 take;
  lenc_t                enc_name;
  lenc_t                enc_cust;
  logic [DBITS_W-1:0]   dcount;
  logic [BYTE_W-1:0]    dmask;

  // a transfer is taken whenever the queue has room
  assign in_ch.ready = !q_full;
  assign take        = in_ch.valid && in_ch.ready;

  assign enc_name = left_encode(in_ch.name_bit_length);
  assign enc_cust = left_encode(cust_len_r);

  // data bit count saturates at one byte
  assign dcount = (in_ch.data_bits > DBITS_W'(BYTE_W)) ? DBITS_W'(BYTE_W) : in_ch.data_bits;
  assign dmask  = BYTE_MASK >> (DBITS_W'(BYTE_W) - dcount);

  // classify the item and build the command
  always_comb begin
    phase_nxt    = phase_r;
    empty_nxt    = empty_r;
    cust_len_nxt = cust_len_r;
    push         = '0;
    if (take) begin
      unique case (op_t'(in_ch.operation))
        OP_BEGIN: begin
          cust_len_nxt = in_ch.custom_bit_length;
          phase_nxt    = PH_NAME;
          empty_nxt    = (in_ch.name_bit_length == '0) && (in_ch.custom_bit_length == '0);
          if (!empty_nxt) begin
            push.valid     = 1'b1;
            push.cmd.kind  = CMD_BEGIN;
            push.cmd.chunk = {enc_name.bits, {eff_rate, 3'b000}, 8'd1};
            push.cmd.len   = CLEN_W'(2 * BYTE_W) + enc_len(enc_name.nbytes);
          end
        end
        OP_SWITCH: begin
          if (phase_r == PH_NAME) begin
            phase_nxt = PH_CUSTOM;
            if (!empty_r) begin
              push.valid     = 1'b1;
              push.cmd.kind  = CMD_APPEND;
              push.cmd.chunk = CHUNK_W'(enc_cust.bits);
              push.cmd.len   = enc_len(enc_cust.nbytes);
            end
          end
        end
        OP_DATA: begin
          if (phase_r != PH_IDLE && !empty_r && dcount != '0) begin
            push.valid     = 1'b1;
            push.cmd.kind  = CMD_APPEND;
            push.cmd.chunk = CHUNK_W'(in_ch.data_byte & dmask);
            push.cmd.len   = CLEN_W'(dcount);
          end
        end
        OP_FINISH: begin
          if (phase_r != PH_IDLE && !empty_r) begin
            push.valid    = 1'b1;
            push.cmd.kind = CMD_FINISH;
          end
          phase_nxt = PH_IDLE;
          empty_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      empty_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      empty_r <= empty_nxt;
    end
  end

  // stored customisation length
  always_ff @(posedge clk) begin
    cust_len_r <= cust_len_nxt;
  end

endmodule

// ===== hw/rtl/cpbp_queue.sv =====
// short command queue between the front and the back
`timescale 1ns / 1ps

module cpbp_queue
  import cpbp_pkg::*;
  #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  q_port_t push,
  output logic    full,
  output q_port_t head,
  input  logic    pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t               slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push;
  logic               do_pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head.valid = (count_r != '0);
  assign head.cmd   = slot_r[rd_ptr_r];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // command storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push.cmd;
    end
  end

endmodule

// ===== hw/rtl/cpbp_back.sv =====
// back end: packs command bits into lanes, pads the rate block and drives the result register
`timescale 1ns / 1ps

module cpbp_back
  import cpbp_pkg::*;
  #(
  parameter int MAX_RATE_LANES = MAX_RATE_LANES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [RATE_W-1:0] eff_rate,
  input  q_port_t           head,
  output logic              pop,
  cpbp_out_if.source        out_ch
);

  localparam int IDX_W = (MAX_RATE_LANES > 1) ? $clog2(MAX_RATE_LANES) : 1;
  localparam int ACC_W = LANE_W + CHUNK_W;
  localparam int CNT_W = $clog2(ACC_W);
  localparam int SH_W  = $clog2(LANE_W);
  localparam int CMP_W = RATE_W + 1;

  logic [ACC_W-1:0]   acc_r, acc_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               pad_r, pad_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LANE_W-1:0]  lane_r, lane_nxt;
  logic               end_r, end_nxt;
  logic               last_r, last_nxt;

  logic               out_free;
  logic               full_lane;
  logic               emit;
  logic               lane_end;
  logic [IDX_W-1:0]   idx_step;
  logic [ACC_W-1:0]   base_acc;
  logic [CNT_W-1:0]   base_cnt;
  logic [IDX_W-1:0]   base_idx;
  logic [CNT_W-1:0]   rounded;
  logic [ACC_W-1:0]   shifted;

  // lane emission, one per cycle while the result register can take it
  assign out_free  = !out_valid_r || out_ch.ready;
  assign full_lane = cnt_r >= CNT_W'(LANE_W);
  assign emit      = out_free && (pad_r || full_lane);
  assign lane_end  = (CMP_W'(idx_r) + CMP_W'(1)) >= CMP_W'(eff_rate);
  assign idx_step  = lane_end ? '0 : idx_r + 1'b1;

  // what is left once this cycle's lane has gone
  assign base_acc = emit ? (acc_r >> LANE_W) : acc_r;
  assign base_cnt = !emit ? cnt_r : (full_lane ? cnt_r - CNT_W'(LANE_W) : '0);
  assign base_idx = emit ? idx_step : idx_r;

  // a command is taken once less than a lane is pending and no padding runs
  assign pop = head.valid && !pad_r && (base_cnt < CNT_W'(LANE_W));

  assign rounded = (base_cnt + CNT_W'(BYTE_W - 1)) & ~CNT_W'(BYTE_W - 1);
  assign shifted = ACC_W'(head.cmd.chunk) << base_cnt[SH_W-1:0];

  // packing state update
  always_comb begin
    acc_nxt = base_acc;
    cnt_nxt = base_cnt;
    idx_nxt = base_idx;
    pad_nxt = pad_r;
    if (emit && pad_r && lane_end) begin
      pad_nxt = 1'b0;
    end
    if (pop) begin
      unique case (head.cmd.kind)
        CMD_BEGIN: begin
          acc_nxt = ACC_W'(head.cmd.chunk);
          cnt_nxt = CNT_W'(head.cmd.len);
          idx_nxt = '0;
        end
        CMD_APPEND: begin
          acc_nxt = base_acc | shifted;
          cnt_nxt = base_cnt + CNT_W'(head.cmd.len);
        end
        CMD_FINISH: begin
          cnt_nxt = rounded;
          pad_nxt = (rounded != '0) || (base_idx != '0);
        end
        default: begin
        end
      endcase
    end
  end

  // result register
  always_comb begin
    out_valid_nxt = emit ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
    lane_nxt      = emit ? acc_r[LANE_W-1:0] : lane_r;
    end_nxt       = emit ? lane_end : end_r;
    last_nxt      = emit ? (pad_r ? lane_end : (cnt_r < CNT_W'(2 * LANE_W))) : last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      idx_r       <= '0;
      pad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      acc_r       <= acc_nxt;
      cnt_r       <= cnt_nxt;
      idx_r       <= idx_nxt;
      pad_r       <= pad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lane_r <= lane_nxt;
    end_r  <= end_nxt;
    last_r <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.lane      = lane_r;
  assign out_ch.block_end = end_r;
  assign out_ch.last      = last_r;

endmodule

// ===== hw/rtl/cpbp_checker.sv =====
// port-level checks on the cshake prefix packer result channel, bound to the top level
`timescale 1ns / 1ps
`include "cshake_prefix_bytepad_packer_unit_macros.svh"

module cpbp_checker
  import cpbp_pkg::*;
  (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input logic [LANE_W-1:0] out_lane,
  input logic              out_block_end,
  input logic              out_last
);

  // a stalled result keeps waiting
  `CPBP_ASSERT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready |=> out_valid, "result valid dropped while stalled")

  // a stalled result keeps its payload
  `CPBP_ASSERT(a_out_payload_hold, clk, rst_n, out_valid && !out_ready |=> $stable(out_lane) && $stable(out_block_end) && $stable(out_last), "result payload changed while stalled")

  // a lane that is not the last of its item is followed at once by the next one
  `CPBP_ASSERT(a_out_burst, clk, rst_n, out_valid && out_ready && !out_last |=> out_valid, "gap inside the lanes of one item")

  // reset empties the result register
  `CPBP_ASSERT_ALWAYS(a_out_reset, clk, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind cshake_prefix_bytepad_packer_unit cpbp_checker u_cpbp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_lane      (out_ch.lane),
  .out_block_end (out_ch.block_end),
  .out_last      (out_ch.last)
);
